// ===== sv/fcs_pkg.sv =====
// shared types, constants and register codes of the fan curve slew controller
package fcs_pkg;

    localparam int SPEED_W = 14;
    localparam int TEMP_W  = 7;
    localparam int STEP_W  = 8;
    localparam int TIN_W   = 19;
    localparam int DEG_W   = 10;
    localparam int TOUT_W  = 9;
    localparam int ACC_W   = SPEED_W + TEMP_W;
    localparam int DIVD_W  = 23;
    localparam int DIVS_W  = 10;
    localparam int CNT_W   = $clog2(DIVD_W);
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int IDX_W   = 3;

    localparam int MILLI_PER_DEG = 1000;
    localparam int ROUND_HALF    = 500;

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x up to 2^18 + 500, the largest rounded input
    localparam int               RECIP_SHIFT = 28;
    localparam logic [TIN_W-1:0] RECIP_1000  = 19'd268436;

    localparam logic [IDX_W-1:0] REG_MIN_SPEED  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_SPEED  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_SPEED = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOW_TEMP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_HIGH_TEMP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_UP    = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP_DOWN  = 3'd6;

    localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 14'd400;
    localparam logic [SPEED_W-1:0] RST_LOW_SPEED  = 14'd500;
    localparam logic [SPEED_W-1:0] RST_HIGH_SPEED = 14'd1600;
    localparam logic [TEMP_W-1:0]  RST_LOW_TEMP   = 7'd40;
    localparam logic [TEMP_W-1:0]  RST_HIGH_TEMP  = 7'd55;

    typedef struct packed {
        logic [SPEED_W-1:0] min_speed;
        logic [SPEED_W-1:0] low_speed;
        logic [SPEED_W-1:0] high_speed;
        logic [TEMP_W-1:0]  low_temp;
        logic [TEMP_W-1:0]  high_temp;
        logic [STEP_W-1:0]  step_up;
        logic [STEP_W-1:0]  step_down;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_CURVE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_START,
        ST_DIV_C,
        ST_CLAMP,
        ST_SLEW,
        ST_DONE
    } state_t;

endpackage

// ===== sv/fan_curve_slew_controller_core.sv =====
// top level of the fan curve slew controller: sequencer, datapath and ports
//
// Takes one temperature request in millidegrees, rounds it to whole degrees
// (halves away from zero), looks up a target speed on a piecewise linear curve
// (min_speed below low_temp, a line from low_speed to high_speed up to
// high_temp, high_speed above), then limits the move from the last speed by
// step_up / step_down. Each request returns fan_speed, a changed flag and the
// rounded temperature. One request is worked on at a time: s_tready is high
// only while the sequencer is idle. The degree rounding is a multiply by a
// fixed reciprocal of 1000. A temperature off the line (or on a line whose
// end temperatures are equal) goes straight to step limiting; one on the
// line first passes two multiply steps and the serial divider, which gives
// one quotient bit per cycle over 23 bits for the line interpolation. A
// finished result sits in the output register and the sequencer is ready
// again the next cycle, so the next request is taken while it waits; that
// request stalls only at its own end if the result is still held.
// Settings go in through the apb port and may be changed only while idle.
module fan_curve_slew_controller_core import fcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [18:0] temp_millideg
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [13:0] fan_speed, [14] speed_changed,
                                         // [23:15] temp_degrees
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg, state_next;

    // datapath registers
    logic                     neg_reg;
    logic [TIN_W-1:0]         rnd_reg;
    logic signed [DEG_W-1:0]  deg_reg;
    logic [TEMP_W-1:0]        span_reg;
    logic [TEMP_W-1:0]        d_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [SPEED_W-1:0]       target_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [SPEED_W-1:0]       last_speed_reg;
    logic                     m_tvalid_reg;
    logic [23:0]              m_tdata_reg;

    // sequencer outputs
    logic start_temp;
    logic start_curve;
    logic ld_deg;
    logic ld_curve;
    logic mul_first;
    logic mul_second;
    logic ld_clamp;
    logic ld_slew;
    logic ld_out;

    logic out_free;
    logic accept;

    fcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fcs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // magnitude of the input, biased by half a degree for rounding
    logic [TIN_W-1:0] t_bits;
    logic             t_neg;
    logic [TIN_W:0]   t_mag;
    logic [TIN_W-1:0] t_rnd;

    always_comb begin
        t_bits = s_tdata[TIN_W-1:0];
        t_neg  = t_bits[TIN_W-1];
        t_mag  = t_neg ? ((TIN_W+1)'(1) << TIN_W) - {1'b0, t_bits} : {1'b0, t_bits};
        t_rnd  = TIN_W'(t_mag + (TIN_W+1)'(ROUND_HALF));
    end

    // curve region tests
    logic signed [DEG_W-1:0] lo_s;
    logic signed [DEG_W-1:0] hi_s;
    logic                    below;
    logic                    above;
    logic [TEMP_W-1:0]       span_c;
    logic [TEMP_W-1:0]       d_c;

    always_comb begin
        lo_s   = $signed({{(DEG_W-TEMP_W){1'b0}}, cfg.low_temp});
        hi_s   = $signed({{(DEG_W-TEMP_W){1'b0}}, cfg.high_temp});
        below  = deg_reg < lo_s;
        above  = deg_reg > hi_s;
        span_c = cfg.high_temp - cfg.low_temp;
        d_c    = deg_reg[TEMP_W-1:0] - cfg.low_temp;
    end

    // single multiplier for the two weighted terms
    logic [SPEED_W-1:0] mul_a;
    logic [TEMP_W-1:0]  mul_b;
    logic [ACC_W-1:0]   product;

    always_comb begin
        mul_a   = mul_second ? cfg.high_speed : cfg.low_speed;
        mul_b   = mul_second ? d_reg : (span_reg - d_reg);
        product = ACC_W'(mul_a) * ACC_W'(mul_b);
    end

    // divider request: (2n + span) / (2 span)
    logic [DIVD_W-1:0] curve_dividend;

    always_comb begin
        curve_dividend   = DIVD_W'({acc_reg, 1'b0}) + DIVD_W'(span_reg);
        div_req.start    = start_curve;
        div_req.dividend = curve_dividend;
        div_req.divisor  = DIVS_W'({span_reg, 1'b0});
    end

    // rounded degrees: divide by 1000 through a reciprocal multiply
    logic [2*TIN_W-1:0] recip_prod;
    logic [TOUT_W-1:0]  deg_mag;
    logic [DEG_W-1:0]   deg_c;

    always_comb begin
        recip_prod = (2*TIN_W)'(rnd_reg) * (2*TIN_W)'(RECIP_1000);
        deg_mag    = recip_prod[RECIP_SHIFT +: TOUT_W];
        deg_c      = neg_reg ? -{1'b0, deg_mag} : {1'b0, deg_mag};
    end

    // clamp the interpolated value between the two line ends
    logic [SPEED_W-1:0] clamp_c;

    always_comb begin
        if (div_rsp.quotient <= DIVD_W'(cfg.low_speed)) begin
            clamp_c = cfg.low_speed;
        end else if (div_rsp.quotient >= DIVD_W'(cfg.high_speed)) begin
            clamp_c = cfg.high_speed;
        end else begin
            clamp_c = div_rsp.quotient[SPEED_W-1:0];
        end
    end

    // step limiting against the kept last speed
    logic [SPEED_W:0]   dn_c;
    logic [SPEED_W:0]   up_c;
    logic [SPEED_W-1:0] slew_c;

    always_comb begin
        dn_c = {1'b0, last_speed_reg} - (SPEED_W+1)'(cfg.step_down);
        up_c = {1'b0, last_speed_reg} + (SPEED_W+1)'(cfg.step_up);
        if ((cfg.step_down != '0) && (target_reg < last_speed_reg)) begin
            // may overshoot the target, floor at min_speed
            if (dn_c[SPEED_W] || (dn_c[SPEED_W-1:0] < cfg.min_speed)) begin
                slew_c = cfg.min_speed;
            end else begin
                slew_c = dn_c[SPEED_W-1:0];
            end
        end else if ((cfg.step_up != '0) && (target_reg > last_speed_reg)) begin
            if (up_c > {1'b0, cfg.high_speed}) begin
                slew_c = cfg.high_speed;
            end else begin
                slew_c = up_c[SPEED_W-1:0];
            end
        end else begin
            slew_c = target_reg;
        end
    end

    // shown temperature saturates to the 9 bit field
    logic [TOUT_W-1:0] shown_c;

    always_comb begin
        if (deg_reg > $signed(DEG_W'(255))) begin
            shown_c = TOUT_W'(255);
        end else if (deg_reg < -$signed(DEG_W'(256))) begin
            shown_c = TOUT_W'(256);
        end else begin
            shown_c = deg_reg[TOUT_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_DIV_T;
            end
            ST_DIV_T:     state_next = ST_CURVE;
            ST_CURVE: begin
                if (below || above || (span_c == '0)) begin
                    state_next = ST_SLEW;
                end else begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_C;
            ST_DIV_C: begin
                if (div_rsp.done) state_next = ST_CLAMP;
            end
            ST_CLAMP:     state_next = ST_SLEW;
            ST_SLEW:      state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        start_temp  = 1'b0;
        start_curve = 1'b0;
        ld_deg      = 1'b0;
        ld_curve    = 1'b0;
        mul_first   = 1'b0;
        mul_second  = 1'b0;
        ld_clamp    = 1'b0;
        ld_slew     = 1'b0;
        ld_out      = 1'b0;
        case (state_reg)
            ST_IDLE:      start_temp  = accept;
            ST_DIV_T:     ld_deg      = 1'b1;
            ST_CURVE:     ld_curve    = 1'b1;
            ST_MUL_A:     mul_first   = 1'b1;
            ST_MUL_B:     mul_second  = 1'b1;
            ST_DIV_START: start_curve = 1'b1;
            ST_DIV_C:     ld_clamp    = div_rsp.done;
            ST_SLEW:      ld_slew     = 1'b1;
            ST_DONE:      ld_out      = out_free;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            last_speed_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (ld_out) begin
                m_tvalid_reg   <= 1'b1;
                last_speed_reg <= speed_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start_temp) begin
            neg_reg <= t_neg;
            rnd_reg <= t_rnd;
        end
        if (ld_deg) begin
            deg_reg <= $signed(deg_c);
        end
        if (ld_curve) begin
            span_reg <= span_c;
            d_reg    <= d_c;
            if (below) begin
                target_reg <= cfg.min_speed;
            end else if (above) begin
                target_reg <= cfg.high_speed;
            end else begin
                // equal end temperatures sit at low_speed
                target_reg <= cfg.low_speed;
            end
        end
        if (mul_first) begin
            acc_reg <= product;
        end
        if (mul_second) begin
            acc_reg <= acc_reg + product;
        end
        if (ld_clamp) begin
            target_reg <= clamp_c;
        end
        if (ld_slew) begin
            speed_reg <= slew_c;
        end
        if (ld_out) begin
            m_tdata_reg <= {shown_c, (speed_reg != last_speed_reg), speed_reg};
        end
    end

endmodule

// ===== sv/fcs_divider.sv =====
// restoring divider, one quotient bit per cycle, used for the line interpolation
module fcs_divider import fcs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;
    logic [DIVS_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/fcs_regs.sv =====
// apb register file holding the curve and step limit settings
module fcs_regs import fcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx   = paddr[APB_AW-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_speed  <= RST_MIN_SPEED;
            cfg_reg.low_speed  <= RST_LOW_SPEED;
            cfg_reg.high_speed <= RST_HIGH_SPEED;
            cfg_reg.low_temp   <= RST_LOW_TEMP;
            cfg_reg.high_temp  <= RST_HIGH_TEMP;
            cfg_reg.step_up    <= '0;
            cfg_reg.step_down  <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_MIN_SPEED:  cfg_reg.min_speed  <= pwdata[SPEED_W-1:0];
                REG_LOW_SPEED:  cfg_reg.low_speed  <= pwdata[SPEED_W-1:0];
                REG_HIGH_SPEED: cfg_reg.high_speed <= pwdata[SPEED_W-1:0];
                REG_LOW_TEMP:   cfg_reg.low_temp   <= pwdata[TEMP_W-1:0];
                REG_HIGH_TEMP:  cfg_reg.high_temp  <= pwdata[TEMP_W-1:0];
                REG_STEP_UP:    cfg_reg.step_up    <= pwdata[STEP_W-1:0];
                REG_STEP_DOWN:  cfg_reg.step_down  <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MIN_SPEED:  prdata = APB_DW'(cfg_reg.min_speed);
            REG_LOW_SPEED:  prdata = APB_DW'(cfg_reg.low_speed);
            REG_HIGH_SPEED: prdata = APB_DW'(cfg_reg.high_speed);
            REG_LOW_TEMP:   prdata = APB_DW'(cfg_reg.low_temp);
            REG_HIGH_TEMP:  prdata = APB_DW'(cfg_reg.high_temp);
            REG_STEP_UP:    prdata = APB_DW'(cfg_reg.step_up);
            REG_STEP_DOWN:  prdata = APB_DW'(cfg_reg.step_down);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
